>>> hdl/jsu_pkg.sv
package jsu_pkg;

   // decoder modes
   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_TEXT = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_HEX  = 3'd3
   } mode_type;

   // result kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_FAIL = 2'd2;

   // characters of interest
   localparam logic [7:0] CHR_QUOTE = 8'h22;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_N = 8'h6E;
   localparam logic [7:0] CHR_R = 8'h72;
   localparam logic [7:0] CHR_T = 8'h74;
   localparam logic [7:0] CHR_U = 8'h75;
   localparam logic [7:0] CHR_LF = 8'h0A;
   localparam logic [7:0] CHR_CR = 8'h0D;
   localparam logic [7:0] CHR_TAB = 8'h09;

   // UTF-8 limits and marks
   localparam logic [15:0] UTF_LIM1 = 16'h007F;
   localparam logic [15:0] UTF_LIM2 = 16'h07FF;
   localparam logic [7:0] UTF_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF_CONT = 8'h80;

   // queue between decoder and serialiser
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // one decoded step: one to three result words
   typedef struct packed {
      logic [1:0]      kind;
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // hex digit check and value
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b0, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

>>> hdl/jsu_front.sv
module jsu_front import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] text_byte,
   input  logic       start_req,
   input  logic       text_end,
   output logic       wr_en,
   output entry_type  wr_entry
);

   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_accum_ff, code_accum_in;

   // hold decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         hex_count_ff <= 2'd0;
         code_accum_ff <= 16'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         hex_count_ff <= hex_count_in;
         code_accum_ff <= code_accum_in;
      end
   end

   // classify the byte and build the word group
   always_comb begin
      mode_type    cur;
      logic [1:0]  hc;
      logic [15:0] acc;
      logic [15:0] cp;
      logic [4:0]  hv;
      logic        closed;

      cur = start_req ? MODE_TEXT : mode_ff;
      hc = start_req ? 2'd0 : hex_count_ff;
      acc = start_req ? 16'd0 : code_accum_ff;
      hv = hex_value(text_byte);
      cp = {acc[11:0], hv[3:0]};
      closed = 1'b0;

      mode_in = cur;
      hex_count_in = hc;
      code_accum_in = acc;
      wr_entry = '0;
      wr_entry.kind = KIND_DATA;

      case (cur)
         MODE_TEXT: begin
            if (text_byte == CHR_QUOTE) begin
               mode_in = MODE_IDLE;
               wr_entry.kind = KIND_DONE;
               wr_entry.count = 2'd1;
               closed = 1'b1;
            end else if (text_byte == CHR_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               wr_entry.count = 2'd1;
               wr_entry.bytes[0] = text_byte;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_TEXT;
            wr_entry.count = 2'd1;
            case (text_byte)
               CHR_N:   wr_entry.bytes[0] = CHR_LF;
               CHR_R:   wr_entry.bytes[0] = CHR_CR;
               CHR_T:   wr_entry.bytes[0] = CHR_TAB;
               CHR_U: begin
                  mode_in = MODE_HEX;
                  hex_count_in = 2'd0;
                  code_accum_in = 16'd0;
                  wr_entry.count = 2'd0;
               end
               default: wr_entry.bytes[0] = text_byte;
            endcase
         end
         MODE_HEX: begin
            if (hv[4]) begin
               // bad digit ends the string at once
               mode_in = MODE_IDLE;
               hex_count_in = 2'd0;
               code_accum_in = 16'd0;
               wr_entry.kind = KIND_FAIL;
               wr_entry.count = 2'd1;
               closed = 1'b1;
            end else if (hc == 2'd3) begin
               mode_in = MODE_TEXT;
               hex_count_in = 2'd0;
               code_accum_in = 16'd0;
               if (cp <= UTF_LIM1) begin
                  wr_entry.count = 2'd1;
                  wr_entry.bytes[0] = cp[7:0];
               end else if (cp <= UTF_LIM2) begin
                  wr_entry.count = 2'd2;
                  wr_entry.bytes[0] = UTF_LEAD2 | {3'b000, cp[10:6]};
                  wr_entry.bytes[1] = UTF_CONT | {2'b00, cp[5:0]};
               end else begin
                  wr_entry.count = 2'd3;
                  wr_entry.bytes[0] = UTF_LEAD3 | {4'b0000, cp[15:12]};
                  wr_entry.bytes[1] = UTF_CONT | {2'b00, cp[11:6]};
                  wr_entry.bytes[2] = UTF_CONT | {2'b00, cp[5:0]};
               end
            end else begin
               hex_count_in = hc + 2'd1;
               code_accum_in = cp;
            end
         end
         default: begin
            // idle: drop the byte, including a last one
            mode_in = MODE_IDLE;
            closed = 1'b1;
         end
      endcase

      // text ran out before the closing quote
      if (text_end && !closed) begin
         mode_in = MODE_IDLE;
         hex_count_in = 2'd0;
         code_accum_in = 16'd0;
         wr_entry = '0;
         wr_entry.kind = KIND_FAIL;
         wr_entry.count = 2'd1;
      end

      wr_en = accept && (wr_entry.count != 2'd0);
   end

endmodule

>>> hdl/jsu_queue.sv
module jsu_queue import jsu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  entry_type wr_entry,
   input  logic      rd_en,
   output entry_type rd_entry,
   output qstat_type status
);

   entry_type           store_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;

   // write the incoming group
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         fill_in = fill_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   assign rd_entry = store_ff[rd_ptr_ff];
   assign status.full = (fill_ff == QCNT_W'(QDEPTH));
   assign status.empty = (fill_ff == '0);

endmodule

>>> hdl/jsu_back.sv
module jsu_back import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       head_empty,
   input  logic       pop,
   output logic       head_done,
   output logic [7:0] out_byte,
   output logic [1:0] kind,
   output logic       run_last
);

   logic [1:0] index_ff, index_in;
   logic       take;

   assign take = pop && !head_empty;
   assign run_last = (index_ff == head.count - 2'd1);
   assign head_done = take && run_last;
   assign kind = head.kind;

   // pick the word within the group
   always_comb begin
      case (index_ff)
         2'd0:    out_byte = head.bytes[0];
         2'd1:    out_byte = head.bytes[1];
         2'd2:    out_byte = head.bytes[2];
         default: out_byte = 8'd0;
      endcase
   end

   // step through the group, restart on the next one
   always_comb begin
      index_in = index_ff;
      if (head_done) begin
         index_in = 2'd0;
      end else if (take) begin
         index_in = index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 2'd0;
      end else begin
         index_ff <= index_in;
      end
   end

endmodule

>>> hdl/json_string_unescape_top.sv
// Decodes a JSON string body one byte per cycle, while the queue is not full,
// into data, done and fail words. A word reaches the rsp ports once its group
// is registered in the queue and earlier groups have been popped. A \u escape
// giving two or three bytes needs as many pops, absorbed by a four-group queue.
// Reset (synchronous): decoder idle, ignoring input until start_req; queue empty.
module json_string_unescape_top import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_text_byte,
   input  logic       req_start_req,
   input  logic       req_text_end,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_run_last
);

   qstat_type q_status;
   entry_type wr_entry;
   entry_type head;
   logic      wr_en;
   logic      head_done;
   logic      accept;

   assign accept = push && !q_status.full;
   assign full = q_status.full;
   assign empty = q_status.empty;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_text_byte),
      .start_req (req_start_req),
      .text_end  (req_text_end),
      .wr_en     (wr_en),
      .wr_entry  (wr_entry)
   );

   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_entry (wr_entry),
      .rd_en    (head_done),
      .rd_entry (head),
      .status   (q_status)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (q_status.empty),
      .pop        (pop),
      .head_done  (head_done),
      .out_byte   (rsp_out_byte),
      .kind       (rsp_kind),
      .run_last   (rsp_run_last)
   );

endmodule
